>>> rtl/core/pvp_pkg.sv
// Package for the perspective vertex projection pipeline.
// Holds the divider depth, register indexes and the side-band word type.
// No dependencies.
package pvp_pkg;

    localparam int DIV_STEPS = 25;
    localparam int CFG_COUNT = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIN_AZ   = 3'd0,
        CFG_COS_AZ   = 3'd1,
        CFG_SIN_EL   = 3'd2,
        CFG_COS_EL   = 3'd3,
        CFG_EYE_DIST = 3'd4,
        CFG_SCR_DIST = 3'd5,
        CFG_NEAR     = 3'd6,
        CFG_FAR      = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [23:0] color;
        logic        ovf_x;
        logic        neg_x;
        logic        ovf_y;
        logic        neg_y;
        logic        behind;
        logic        dzero;
        logic        full;
    } side_t;

endpackage

>>> rtl/core/perspective_vertex_projection_top.sv
// Top level of the perspective vertex projection pipeline.
// Depends on pvp_pkg and pvp_div_pipe.
//
// One vertex word enters and one result word leaves per cycle while the output is not
// stalled; stages A to E feed the 25-stage restoring dividers for screen x, screen y
// and depth, then the output register. All stages advance together whenever the output
// register is empty or being taken, so a stall holds every word in place. Configuration
// registers are read by the stages as words pass, so a write can reach words in flight.
module perspective_vertex_projection_top
    import pvp_pkg::*;
#(
    parameter int COORD_WIDTH      = 16,
    parameter int TRIG_FRAC_BITS   = 14,
    parameter int SCREEN_FRAC_BITS = 8
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_we,
    input  logic [CFG_IDX_W-1:0]                     cfg_index,
    input  logic [CFG_W-1:0]                         cfg_wdata,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // world_x, world_y, world_z, vertex_color
    input  logic [((3*COORD_WIDTH+31)/8)*8-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // screen_x, screen_y, screen_depth, pixel_color
    output logic [79:0]                              m_tdata,
    // behind_eye
    output logic                                     m_tuser
);
    localparam int CW   = COORD_WIDTH;
    localparam int TF   = TRIG_FRAC_BITS;
    localparam int SF   = SCREEN_FRAC_BITS;
    localparam int KW   = 34 - TF;
    localparam int MW   = (KW > 16) ? KW : 16;
    localparam int PW   = CW + MW;
    localparam int EW   = ((PW > 17 + TF) ? PW : 17 + TF) + 3;
    localparam int QW   = EW + 17;
    localparam int NXW  = EW + SF + 19;
    localparam int NYW  = EW + 19;
    localparam int NDW  = EW + 18;
    localparam int DNW  = NDW - 1 + 17;
    localparam logic signed [33:0] HALF = 34'sd1 <<< (TF - 1);

    // configuration
    logic signed [15:0] sin_az_reg, cos_az_reg, sin_el_reg, cos_el_reg;
    logic        [15:0] eye_dist_reg, scr_dist_reg, near_reg, far_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sin_az_reg   <= 16'sd0;
            cos_az_reg   <= 16'sd16384;
            sin_el_reg   <= 16'sd16384;
            cos_el_reg   <= 16'sd0;
            eye_dist_reg <= 16'd1000;
            scr_dist_reg <= 16'd800;
            near_reg     <= 16'd200;
            far_reg      <= 16'd1200;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_SIN_AZ:   sin_az_reg   <= $signed(cfg_wdata);
                CFG_COS_AZ:   cos_az_reg   <= $signed(cfg_wdata);
                CFG_SIN_EL:   sin_el_reg   <= $signed(cfg_wdata);
                CFG_COS_EL:   cos_el_reg   <= $signed(cfg_wdata);
                CFG_EYE_DIST: eye_dist_reg <= cfg_wdata;
                CFG_SCR_DIST: scr_dist_reg <= cfg_wdata;
                CFG_NEAR:     near_reg     <= cfg_wdata;
                CFG_FAR:      far_reg      <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // rotation products, refreshed from configuration every cycle
    logic signed [33:0]   k5_next, k6_next, k7_next, k8_next;
    logic signed [KW-1:0] k5_reg, k6_reg, k7_reg, k8_reg;

    always_comb begin
        k5_next = 34'(sin_el_reg * cos_az_reg) + HALF;
        k6_next = 34'(sin_el_reg * sin_az_reg) + HALF;
        k7_next = 34'(cos_el_reg * cos_az_reg) + HALF;
        k8_next = 34'(cos_el_reg * sin_az_reg) + HALF;
    end

    always_ff @(posedge aclk) begin
        k5_reg <= k5_next[33:TF];
        k6_reg <= k6_next[33:TF];
        k7_reg <= k7_next[33:TF];
        k8_reg <= k8_next[33:TF];
    end

    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // stage A: input word
    logic                 va_reg;
    logic signed [CW-1:0] xa_reg, ya_reg, za_reg;
    logic [23:0]          ca_reg;

    // stage B: products
    logic                 vb_reg;
    logic signed [PW-1:0] p_xca_reg, p_zsa_reg, p_xk8_reg, p_yse_reg, p_zk7_reg;
    logic signed [PW-1:0] p_xk6_reg, p_yce_reg, p_zk5_reg;
    logic [23:0]          cb_reg;

    // stage C: eye space
    logic                 vc_reg;
    logic signed [EW-1:0] ex_reg, ey_reg, ez_reg;
    logic [23:0]          cc_reg;

    // stage D: numerators and depth terms
    logic                  vd_reg;
    logic signed [QW-1:0]  px_reg, py_reg;
    logic signed [NDW-1:0] dnum_reg, dden_reg;
    logic signed [EW-1:0]  ezd_reg;
    logic                  behind_d_reg, dzero_d_reg;
    logic [23:0]           cd_reg;

    // stage E: divider operands
    logic                  ve_reg;
    logic [NXW-1:0]        ax_reg;
    logic [NYW-1:0]        ay_reg;
    logic [EW-1:0]         d2_reg;
    logic [DNW-1:0]        nd_reg;
    logic [NDW-2:0]        dd_reg;
    side_t                 side_e_reg;

    logic signed [EW-1:0]  ez_next, near_sh;
    logic signed [EW:0]    dz_next;
    logic signed [NXW-1:0] nx_next;
    logic signed [NYW-1:0] ny_next;
    logic [NXW-1:0]        ax_next;
    logic [NYW-1:0]        ay_next;
    logic [EW-1:0]         d2_next;

    always_comb begin
        ez_next = - EW'(p_xk6_reg) - EW'(p_yce_reg) - EW'(p_zk5_reg)
                  + $signed(EW'({1'b0, eye_dist_reg}) << TF);
        near_sh = $signed(EW'({1'b0, near_reg}) << TF);
        dz_next = (EW+1)'(ez_reg) - (EW+1)'(near_sh);
        nx_next = (NXW'(px_reg) <<< (SF + 1)) + NXW'(ezd_reg);
        ny_next = (NYW'(py_reg) <<< 1) + NYW'(ezd_reg);
        ax_next = nx_next[NXW-1] ? NXW'(-nx_next) : NXW'(nx_next);
        ay_next = ny_next[NYW-1] ? NYW'(-ny_next) : NYW'(ny_next);
        d2_next = {ezd_reg[EW-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xa_reg <= $signed(s_tdata[CW-1:0]);
            ya_reg <= $signed(s_tdata[2*CW-1:CW]);
            za_reg <= $signed(s_tdata[3*CW-1:2*CW]);
            ca_reg <= s_tdata[3*CW+23:3*CW];

            p_xca_reg <= xa_reg * cos_az_reg;
            p_zsa_reg <= za_reg * sin_az_reg;
            p_xk8_reg <= xa_reg * k8_reg;
            p_yse_reg <= ya_reg * sin_el_reg;
            p_zk7_reg <= za_reg * k7_reg;
            p_xk6_reg <= xa_reg * k6_reg;
            p_yce_reg <= ya_reg * cos_el_reg;
            p_zk5_reg <= za_reg * k5_reg;
            cb_reg    <= ca_reg;

            ex_reg <= EW'(p_xca_reg) - EW'(p_zsa_reg);
            ey_reg <= - EW'(p_xk8_reg) + EW'(p_yse_reg) - EW'(p_zk7_reg);
            ez_reg <= ez_next;
            cc_reg <= cb_reg;

            px_reg       <= $signed({1'b0, scr_dist_reg}) * ex_reg;
            py_reg       <= $signed({1'b0, scr_dist_reg}) * ey_reg;
            dnum_reg     <= $signed({1'b0, far_reg}) * dz_next;
            dden_reg     <= ez_reg * ($signed({1'b0, far_reg}) - $signed({1'b0, near_reg}));
            ezd_reg      <= ez_reg;
            behind_d_reg <= ez_reg <= 0;
            dzero_d_reg  <= (far_reg <= near_reg) || (ez_reg <= near_sh);
            cd_reg       <= cc_reg;

            ax_reg            <= ax_next;
            ay_reg            <= ay_next;
            d2_reg            <= d2_next;
            nd_reg            <= {dnum_reg[NDW-2:0], 17'd0};
            dd_reg            <= dden_reg[NDW-2:0];
            side_e_reg.color  <= cd_reg;
            side_e_reg.ovf_x  <= ax_next >= {d2_next, {DIV_STEPS{1'b0}}};
            side_e_reg.neg_x  <= nx_next[NXW-1];
            side_e_reg.ovf_y  <= ay_next >= {d2_next, {DIV_STEPS{1'b0}}};
            side_e_reg.neg_y  <= ny_next[NYW-1];
            side_e_reg.behind <= behind_d_reg;
            side_e_reg.dzero  <= dzero_d_reg;
            side_e_reg.full   <= dnum_reg >= dden_reg;
        end
    end

    // dividers
    logic [DIV_STEPS-1:0] qx, qy, qd;
    logic                 nzx, nzy, nzd;

    pvp_div_pipe #(.NUM_W(NXW), .DEN_W(EW)) u_div_x (
        .aclk(aclk), .en(en), .num(ax_reg), .den(d2_reg), .quot(qx), .rem_nz(nzx)
    );
    pvp_div_pipe #(.NUM_W(NYW), .DEN_W(EW)) u_div_y (
        .aclk(aclk), .en(en), .num(ay_reg), .den(d2_reg), .quot(qy), .rem_nz(nzy)
    );
    pvp_div_pipe #(.NUM_W(DNW), .DEN_W(NDW-1)) u_div_d (
        .aclk(aclk), .en(en), .num(nd_reg), .den(dd_reg), .quot(qd), .rem_nz(nzd)
    );

    // side-band delay alongside the dividers
    side_t side_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] vdiv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vdiv_reg <= '0;
        end else if (en) begin
            vdiv_reg <= {vdiv_reg[DIV_STEPS-2:0], ve_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_e_reg;
            for (int i = 1; i < DIV_STEPS; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // final rounding, saturation and masking
    side_t        sf;
    logic [25:0]  magx, magy;
    logic [17:0]  rd;
    logic [23:0]  sx_next;
    logic [15:0]  sy_next, dep_next;
    logic [79:0]  data_next;

    always_comb begin
        sf   = side_reg[DIV_STEPS-1];
        magx = {1'b0, qx} + 26'(nzx);
        magy = {1'b0, qy} + 26'(nzy);
        rd   = ({1'b0, qd[16:0]} + 18'd1) >> 1;

        if (sf.ovf_x) begin
            sx_next = sf.neg_x ? 24'h800000 : 24'h7FFFFF;
        end else if (!sf.neg_x) begin
            sx_next = (qx >= 25'd8388608) ? 24'h7FFFFF : qx[23:0];
        end else begin
            sx_next = (magx > 26'd8388608) ? 24'h800000 : 24'(-magx);
        end

        if (sf.ovf_y) begin
            sy_next = sf.neg_y ? 16'h8000 : 16'h7FFF;
        end else if (!sf.neg_y) begin
            sy_next = (qy >= 25'd32768) ? 16'h7FFF : qy[15:0];
        end else begin
            sy_next = (magy > 26'd32768) ? 16'h8000 : 16'(-magy);
        end

        if (sf.dzero) begin
            dep_next = 16'd0;
        end else if (sf.full || rd[16]) begin
            dep_next = 16'hFFFF;
        end else begin
            dep_next = rd[15:0];
        end

        if (sf.behind) begin
            data_next = '0;
        end else begin
            data_next = {sf.color, dep_next, sy_next, sx_next};
        end
    end

    logic [79:0] m_tdata_reg;
    logic        m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vdiv_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= data_next;
            m_tuser_reg <= sf.behind;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> rtl/core/pvp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on pvp_pkg for DIV_STEPS; caller keeps num below den * 2^DIV_STEPS.
module pvp_div_pipe
    import pvp_pkg::*;
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [NUM_W-1:0]     num,
    input  logic [DEN_W-1:0]     den,
    output logic [DIV_STEPS-1:0] quot,
    output logic                 rem_nz
);
    localparam int CMP_W = (NUM_W > DEN_W + DIV_STEPS) ? NUM_W : DEN_W + DIV_STEPS;

    logic [NUM_W-1:0]     rem_reg  [DIV_STEPS];
    logic [DEN_W-1:0]     den_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] quot_reg [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        logic [NUM_W-1:0]     rem_in;
        logic [DEN_W-1:0]     den_in;
        logic [DIV_STEPS-1:0] quot_in;
        logic [CMP_W-1:0]     trial;
        logic [CMP_W-1:0]     diff;
        logic                 take;

        if (j == 0) begin : g_first
            assign rem_in  = num;
            assign den_in  = den;
            assign quot_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign quot_in = quot_reg[j-1];
        end

        assign trial = CMP_W'(den_in) << (DIV_STEPS - 1 - j);
        assign take  = CMP_W'(rem_in) >= trial;
        assign diff  = CMP_W'(rem_in) - trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= take ? diff[NUM_W-1:0] : rem_in;
                den_reg[j]  <= den_in;
                quot_reg[j] <= quot_in | (take ? (DIV_STEPS'(1) << (DIV_STEPS - 1 - j))
                                               : DIV_STEPS'(0));
            end
        end
    end

    assign quot   = quot_reg[DIV_STEPS-1] | {DIV_STEPS{1'b0 & |den_reg[DIV_STEPS-1]}};
    assign rem_nz = |rem_reg[DIV_STEPS-1];

endmodule

>>> tb/perspective_vertex_projection_top_tb.sv
// Self-checking testbench for perspective_vertex_projection_top.
// Directed vertices and random bursts are driven; results are checked against a built-in
// projection model for several view settings. Depends on pvp_pkg and the RTL top level only.
module perspective_vertex_projection_top_tb;
    import pvp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [23:0] color;
        logic [15:0] depth;
        logic [15:0] sy;
        logic [23:0] sx;
        logic        behind;
    } projection_t;

    class projection_scoreboard;
        logic [15:0] view_regs [CFG_COUNT];
        projection_t pending [$];
        int errors;
        int vertices_seen;
        int results_seen;
        int behind_seen;
        int depth_full_seen;

        function new();
            view_regs = '{16'd0, 16'd16384, 16'd16384, 16'd0,
                          16'd1000, 16'd800, 16'd200, 16'd1200};
            errors = 0;
            vertices_seen = 0;
            results_seen = 0;
            behind_seen = 0;
            depth_full_seen = 0;
        endfunction

        function longint fdiv(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) < 0) q = q - 1;
            return q;
        endfunction

        function longint trig_product(longint a, longint b);
            return fdiv(a * b + 8192, 16384);
        endfunction

        function longint nearest(longint n, longint d);
            return fdiv(2 * n + d, 2 * d);
        endfunction

        function void note_vertex(logic [71:0] word);
            longint x, y, z, sa, ca, se, ce, eye_d, scr_d, near_d, far_d;
            longint k5, k6, k7, k8, ex, ey, ez, sx, sy, depth, num, den, r, q;
            projection_t p;
            x = $signed(word[15:0]);
            y = $signed(word[31:16]);
            z = $signed(word[47:32]);
            sa = $signed(view_regs[CFG_SIN_AZ]);
            ca = $signed(view_regs[CFG_COS_AZ]);
            se = $signed(view_regs[CFG_SIN_EL]);
            ce = $signed(view_regs[CFG_COS_EL]);
            eye_d = view_regs[CFG_EYE_DIST];
            scr_d = view_regs[CFG_SCR_DIST];
            near_d = view_regs[CFG_NEAR];
            far_d = view_regs[CFG_FAR];
            vertices_seen++;
            k5 = trig_product(se, ca);
            k6 = trig_product(se, sa);
            k7 = trig_product(ce, ca);
            k8 = trig_product(ce, sa);
            ex = x * ca - z * sa;
            ey = -x * k8 + y * se - z * k7;
            ez = -x * k6 - y * ce - z * k5 + eye_d * 16384;
            p = '0;
            if (ez <= 0) begin
                p.behind = 1'b1;
                pending.push_back(p);
                return;
            end
            sx = nearest(scr_d * ex * 256, ez);
            if (sx > 8388607) sx = 8388607;
            if (sx < -8388608) sx = -8388608;
            sy = nearest(scr_d * ey, ez);
            if (sy > 32767) sy = 32767;
            if (sy < -32768) sy = -32768;
            if (far_d <= near_d || ez <= near_d * 16384) begin
                depth = 0;
            end else begin
                num = far_d * (ez - near_d * 16384);
                den = ez * (far_d - near_d);
                if (num >= den) begin
                    depth = 65535;
                end else begin
                    r = num;
                    q = 0;
                    for (int i = 0; i < 17; i++) begin
                        r = 2 * r;
                        q = 2 * q;
                        if (r >= den) begin
                            r = r - den;
                            q = q + 1;
                        end
                    end
                    depth = (q + 1) / 2;
                    if (depth > 65535) depth = 65535;
                end
            end
            p.sx = sx[23:0];
            p.sy = sy[15:0];
            p.depth = depth[15:0];
            p.color = word[71:48];
            pending.push_back(p);
        endfunction

        function void check_result(logic [79:0] word, logic flag);
            projection_t e;
            results_seen++;
            if (pending.size() == 0) begin
                $error("result with no vertex pending: data %h behind %b", word, flag);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (flag) behind_seen++;
            if (e.depth == 16'hFFFF) depth_full_seen++;
            if (word[23:0] !== e.sx) begin
                $error("screen_x: expected %h actual %h", e.sx, word[23:0]);
                errors++;
            end
            if (word[39:24] !== e.sy) begin
                $error("screen_y: expected %h actual %h", e.sy, word[39:24]);
                errors++;
            end
            if (word[55:40] !== e.depth) begin
                $error("screen_depth: expected %h actual %h", e.depth, word[55:40]);
                errors++;
            end
            if (word[79:56] !== e.color) begin
                $error("pixel_color: expected %h actual %h", e.color, word[79:56]);
                errors++;
            end
            if (flag !== e.behind) begin
                $error("behind_eye: expected %b actual %b", e.behind, flag);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tuser;

    projection_scoreboard sb = new();
    int idle_cycles = 0;
    int phases_run = 0;

    perspective_vertex_projection_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_vertex(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("watchdog: no progress, %0d results pending", sb.pending.size());
            $display("[perspective_vertex_projection_top] ERROR");
            $finish;
        end
    end

    // receiver: alternate free-flowing, random and heavy-stall stretches
    initial begin
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0: m_tready = 1'b1;
                    1: m_tready = 1'($urandom_range(0, 1));
                    default: m_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic write_view_reg(cfg_idx_t idx, logic [15:0] value);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        sb.view_regs[idx] = value;
    endtask

    task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                               logic [23:0] color);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = {color, z, y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic hold_off(int cycles);
        @(negedge aclk);
        s_tvalid = 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    task automatic drain;
        hold_off(0);
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 4000)) - 2000);
            2: return 16'($signed($urandom_range(0, 400)) - 200);
            default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    task automatic random_vertices(int count);
        int left;
        left = count;
        while (left > 0) begin
            int burst;
            burst = $urandom_range(1, 40);
            while (burst > 0 && left > 0) begin
                send_vertex(pick_coord(), pick_coord(), pick_coord(), 24'($urandom));
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) != 0) hold_off($urandom_range(0, 12));
        end
    endtask

    task automatic random_view;
        for (int i = 0; i < CFG_COUNT; i++) begin
            logic [15:0] v;
            if (i < 4)
                v = 16'($signed($urandom_range(0, 32768)) - 16384);
            else
                v = 16'($urandom_range(1, 3000));
            write_view_reg(cfg_idx_t'(i), v);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset view: depth falls at z=800, vertex behind eye from z=1000
        send_vertex(16'd0, 16'd0, 16'd0, 24'h000000);
        send_vertex(16'd0, 16'd0, 16'd1000, 24'hFFFFFF);
        send_vertex(16'd5, 16'd5, 16'd999, 24'h123456);
        send_vertex(16'h7FFF, 16'h7FFF, 16'd999, 24'hABCDEF);
        send_vertex(16'h8000, 16'h8000, 16'd999, 24'h555555);
        send_vertex(16'd10, 16'd10, 16'd800, 24'hAAAAAA);
        send_vertex(16'd10, 16'd10, 16'd801, 24'h0F0F0F);
        send_vertex(16'h7FFF, 16'h8000, 16'h8000, 24'hF0F0F0);
        send_vertex(16'h8000, 16'h7FFF, 16'h7FFF, 24'h808080);
        send_vertex(16'hFFFF, 16'h0001, 16'hFC18, 24'h7F7F7F);
        random_vertices(80);
        drain();

        // extreme trig values, far not above near, zero screen distance
        write_view_reg(CFG_SIN_AZ, 16'hC000);
        write_view_reg(CFG_COS_AZ, 16'h4000);
        write_view_reg(CFG_SIN_EL, 16'hC000);
        write_view_reg(CFG_COS_EL, 16'h4000);
        write_view_reg(CFG_EYE_DIST, 16'hFFFF);
        write_view_reg(CFG_SCR_DIST, 16'h0000);
        write_view_reg(CFG_NEAR, 16'd500);
        write_view_reg(CFG_FAR, 16'd500);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 24'h010203);
        send_vertex(16'h8000, 16'h8000, 16'h8000, 24'h040506);
        random_vertices(80);
        drain();

        // trig registers at the Q1.14 limits, outside +-1, maximum distances
        write_view_reg(CFG_SIN_AZ, 16'h7FFF);
        write_view_reg(CFG_COS_AZ, 16'h8000);
        write_view_reg(CFG_SIN_EL, 16'h7FFF);
        write_view_reg(CFG_COS_EL, 16'h8000);
        write_view_reg(CFG_SCR_DIST, 16'hFFFF);
        write_view_reg(CFG_NEAR, 16'd1);
        write_view_reg(CFG_FAR, 16'hFFFF);
        random_vertices(80);
        drain();

        // smallest eye distance, near and far at the limits
        write_view_reg(CFG_SIN_AZ, 16'd0);
        write_view_reg(CFG_COS_AZ, 16'd16384);
        write_view_reg(CFG_SIN_EL, 16'd16384);
        write_view_reg(CFG_COS_EL, 16'd0);
        write_view_reg(CFG_EYE_DIST, 16'd1);
        write_view_reg(CFG_SCR_DIST, 16'd1);
        write_view_reg(CFG_NEAR, 16'hFFFF);
        write_view_reg(CFG_FAR, 16'd2);
        send_vertex(16'd0, 16'd0, 16'd0, 24'hC0FFEE);
        send_vertex(16'd0, 16'd0, 16'hFFFF, 24'h00FF00);
        random_vertices(60);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            random_view();
            random_vertices(80);
            drain();
            phases_run++;
        end

        $display("covered %0d vertices, %0d results over %0d view settings",
                 sb.vertices_seen, sb.results_seen, phases_run + 4);
        $display("%0d behind the eye, %0d at full depth", sb.behind_seen, sb.depth_full_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[perspective_vertex_projection_top] OK");
        end else begin
            $display("[perspective_vertex_projection_top] ERROR");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/core/pvp_pkg.sv
rtl/core/pvp_div_pipe.sv
rtl/core/perspective_vertex_projection_top.sv
tb/perspective_vertex_projection_top_tb.sv
